### rtl/fcp_pkg.sv
// Shared types and constants for the pinned FIFO tag store.
package fcp_pkg;

  localparam int KEY_W      = 31;
  localparam int POS_W      = 4;
  localparam int CAP_W      = 5;
  localparam int STATUS_W   = 2;
  localparam int PDATA_W    = 32;
  localparam int PADDR_W    = 2;

  localparam logic [CAP_W-1:0]   CAPACITY_RESET = 5'd15;
  localparam logic [PADDR_W-1:0] ADDR_CAPACITY  = 2'd0;

  localparam logic OP_LOOKUP  = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ALL_PINNED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT     = 2'd2;

  typedef enum logic {
    FCP_IDLE,
    FCP_UPD
  } fcp_state_e;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic             capture;
    logic             commit;
    logic             evict;
    logic             insert;
    logic             op;
    logic [KEY_W-1:0] key;
  } fcp_bcast_t;

endpackage

### rtl/fcp_cell.sv
// One entry of the tag store: key, pin bit, match flag, neighbor shift.
module fcp_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  fcp_pkg::fcp_bcast_t       bc_i,
  input  logic                      valid_i,
  input  logic                      load_i,
  input  logic                      free_i,
  input  logic                      shift_i,
  input  logic [fcp_pkg::KEY_W-1:0] nb_key_i,
  input  logic                      nb_pinned_i,
  output logic [fcp_pkg::KEY_W-1:0] key_o,
  output logic                      pinned_o,
  output logic                      match_o,
  output logic                      free_o,
  output logic                      shift_o,
  output logic [fcp_pkg::KEY_W-1:0] victim_key_o
);
  import fcp_pkg::*;

  logic [KEY_W-1:0] key_q;
  logic             pinned_q;
  logic             match_q;
  logic             victim;
  logic             shift_here;

  assign victim       = valid_i & ~pinned_q & ~free_i;
  assign free_o       = free_i | (valid_i & ~pinned_q);
  assign shift_o      = shift_i | victim;
  assign shift_here   = bc_i.evict & (shift_i | victim);
  assign victim_key_o = victim ? key_q : '0;
  assign key_o        = key_q;
  assign pinned_o     = pinned_q;
  assign match_o      = match_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pinned_q <= 1'b0;
      match_q  <= 1'b0;
    end else begin
      if (bc_i.capture) begin
        match_q <= valid_i & (key_q == bc_i.key);
      end
      if (bc_i.commit) begin
        if (bc_i.insert && load_i) begin
          pinned_q <= 1'b1;
        end else if (shift_here) begin
          pinned_q <= nb_pinned_i;
        end else if (match_q) begin
          pinned_q <= (bc_i.op == OP_LOOKUP);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (bc_i.commit) begin
      if (bc_i.insert && load_i) begin
        key_q <= bc_i.key;
      end else if (shift_here) begin
        key_q <= nb_key_i;
      end
    end
  end

endmodule

### rtl/fifo_cache_with_pinning.sv
// Top level: pinned FIFO tag store built as a row of entry cells.
//
//  channel | handshake            | words
//  --------+----------------------+---------------------------------------------
//  in      | in_valid_i/in_stall_o | operation_i, key_i
//  out     | out_valid_o/out_stall_i | hit_o, position_o, fill_needed_o, evicted_o,
//          |                      | evicted_key_o, status_o
//  cfg     | APB write/read       | capacity at address 0
//
// Each word has an accept cycle, which compares the key in every cell, and an
// update cycle, which resolves hit/victim along the cell row and shifts/inserts.
// A result that is still held by out_stall_i delays the update cycle.
// Reset empties the store at once (count and pin bits); no clearing pass.
// in_stall_o is high during the update cycle only.
module fifo_cache_with_pinning #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fcp_pkg::PADDR_W-1:0]  paddr,
  input  logic [fcp_pkg::PDATA_W-1:0]  pwdata,
  output logic [fcp_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         operation_i,
  input  logic [fcp_pkg::KEY_W-1:0]    key_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         hit_o,
  output logic [fcp_pkg::POS_W-1:0]    position_o,
  output logic                         fill_needed_o,
  output logic                         evicted_o,
  output logic [fcp_pkg::KEY_W-1:0]    evicted_key_o,
  output logic [fcp_pkg::STATUS_W-1:0] status_o
);
  import fcp_pkg::*;

  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
  localparam int EW   = (CW > POS_W) ? CW : POS_W;

  fcp_state_e       state_q, state_d;
  logic [CAP_W-1:0] cap_q;
  logic [CW-1:0]    count_q, count_d;
  logic             op_q;
  logic [KEY_W-1:0] key_q;
  logic             accept, commit;

  logic                         out_valid_q, out_valid_d;
  logic                         hit_q;
  logic [POS_W-1:0]             pos_q;
  logic                         fill_q;
  logic                         ev_q;
  logic [KEY_W-1:0]             evk_q;
  logic [STATUS_W-1:0]          status_q;

  fcp_bcast_t       bc;
  logic [KEY_W-1:0] key_chain   [MAX_ENTRIES];
  logic [KEY_W-1:0] vkey_chain  [MAX_ENTRIES];
  logic             pin_chain   [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] match_vec;
  logic [MAX_ENTRIES:0]   free_chain;
  logic [MAX_ENTRIES:0]   shift_chain;

  logic             cfg_wr;
  logic [CMPW-1:0]  cap_ext, eff_cap;
  logic             any_hit, need_ev, blocked, do_evict, do_insert;
  logic [EW-1:0]    hit_pos;
  logic [CW-1:0]    count_after;
  logic [KEY_W-1:0] victim_key;
  logic             res_hit, res_fill, res_ev;
  logic [EW-1:0]    res_pos;
  logic [KEY_W-1:0] res_evk;
  logic [STATUS_W-1:0] res_status;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr == ADDR_CAPACITY);
  assign prdata = (paddr == ADDR_CAPACITY) ? PDATA_W'(cap_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAPACITY_RESET;
    end else if (cfg_wr) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  // control
  always_comb begin
    state_d = state_q;
    case (state_q)
      FCP_IDLE: if (in_valid_i) state_d = FCP_UPD;
      FCP_UPD:  if (commit) state_d = FCP_IDLE;
      default:  state_d = FCP_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    accept     = 1'b0;
    commit     = 1'b0;
    case (state_q)
      FCP_IDLE: begin
        in_stall_o = 1'b0;
        accept     = in_valid_i;
      end
      FCP_UPD: commit = ~out_valid_q | ~out_stall_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FCP_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= operation_i;
      key_q <= key_i;
    end
  end

  // resolve
  assign cap_ext = CMPW'(cap_q);
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CMPW'(1);
    end else if (cap_ext > CMPW'(MAX_ENTRIES)) begin
      eff_cap = CMPW'(MAX_ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  always_comb begin
    hit_pos    = '0;
    victim_key = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (match_vec[i]) hit_pos = hit_pos | EW'(i);
      victim_key = victim_key | vkey_chain[i];
    end
  end

  assign any_hit     = |match_vec;
  assign need_ev     = CMPW'(count_q) >= eff_cap;
  assign blocked     = need_ev & ~free_chain[MAX_ENTRIES];
  assign do_evict    = commit & (op_q == OP_LOOKUP) & ~any_hit & need_ev & ~blocked;
  assign do_insert   = (op_q == OP_LOOKUP) & ~any_hit & ~blocked;
  assign count_after = count_q - CW'(do_evict);

  always_comb begin
    res_hit    = 1'b0;
    res_pos    = '0;
    res_fill   = 1'b0;
    res_ev     = 1'b0;
    res_evk    = '0;
    res_status = ST_OK;
    if (op_q == OP_RELEASE) begin
      if (any_hit) begin
        res_hit = 1'b1;
        res_pos = hit_pos;
      end else begin
        res_status = ST_ABSENT;
      end
    end else if (any_hit) begin
      res_hit = 1'b1;
      res_pos = hit_pos;
    end else if (blocked) begin
      res_status = ST_ALL_PINNED;
    end else begin
      res_fill = 1'b1;
      res_pos  = EW'(count_after);
      if (need_ev) begin
        res_ev  = 1'b1;
        res_evk = victim_key;
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (commit && do_insert) begin
      count_d = count_after + CW'(1);
    end
  end

  // cell row
  assign bc.capture = accept;
  assign bc.commit  = commit;
  assign bc.evict   = do_evict;
  assign bc.insert  = do_insert;
  assign bc.op      = op_q;
  assign bc.key     = (state_q == FCP_IDLE) ? key_i : key_q;

  assign free_chain[0]  = 1'b0;
  assign shift_chain[0] = 1'b0;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    logic [KEY_W-1:0] nb_key;
    logic             nb_pin;
    if (g + 1 < MAX_ENTRIES) begin : g_nb
      assign nb_key = key_chain[g+1];
      assign nb_pin = pin_chain[g+1];
    end else begin : g_end
      assign nb_key = '0;
      assign nb_pin = 1'b0;
    end
    fcp_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .bc_i         (bc),
      .valid_i      (CW'(g) < count_q),
      .load_i       (CW'(g) == count_after),
      .free_i       (free_chain[g]),
      .shift_i      (shift_chain[g]),
      .nb_key_i     (nb_key),
      .nb_pinned_i  (nb_pin),
      .key_o        (key_chain[g]),
      .pinned_o     (pin_chain[g]),
      .match_o      (match_vec[g]),
      .free_o       (free_chain[g+1]),
      .shift_o      (shift_chain[g+1]),
      .victim_key_o (vkey_chain[g])
    );
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      hit_q    <= res_hit;
      pos_q    <= res_pos[POS_W-1:0];
      fill_q   <= res_fill;
      ev_q     <= res_ev;
      evk_q    <= res_evk;
      status_q <= res_status;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_q;
  assign position_o    = pos_q;
  assign fill_needed_o = fill_q;
  assign evicted_o     = ev_q;
  assign evicted_key_o = evk_q;
  assign status_o      = status_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMPW'(count_q) <= CMPW'(MAX_ENTRIES))
    else $error("entry count above the number of cells");

  a_unique_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FCP_UPD) |-> $onehot0(match_vec))
    else $error("key matched in more than one cell");

  a_evict_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && ev_q) |-> (fill_q && status_q == ST_OK && !hit_q))
    else $error("eviction without insert");

  a_commit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && res_fill) |=> (count_q == $past(count_after) + CW'(1)))
    else $error("count not advanced by an insert");

endmodule
